>>> sv/smx_pkg.sv
// Shared types, constants and float32/bf16 arithmetic functions for the stream mixer.
`timescale 1ns / 1ps
`default_nettype none
package smx_pkg;

  localparam int NS       = 4;
  localparam int MIX_N    = NS * NS;
  localparam int IDX_W    = $clog2(MIX_N);
  localparam int GAIN_W   = $clog2(NS);
  localparam logic [31:0] QNAN_F32 = 32'h7FC0_0000;
  localparam logic [15:0] QNAN_BF16 = 16'h7FC0;

  typedef enum logic [1:0] {
    OP_MIX,
    OP_GAIN,
    OP_DATA
  } smx_op_e;

  typedef struct packed {
    smx_op_e                op;
    logic [IDX_W-1:0]       idx;
    logic [31:0]            value;
    logic [15:0]            layer;
    logic [NS-1:0][15:0]    res;
  } smx_entry_t;

  // Round a magnitude m * 2^e_in to float32, nearest-even, subnormals kept.
  function automatic logic [30:0] pack_mag(input logic [31:0] m, input int e_in);
    int          lz;
    int          e;
    int          sh;
    int          field;
    logic [31:0] mn;
    logic [31:0] t;
    logic        lost;
    logic [23:0] man;
    logic        g;
    logic        st;
    logic        inc;
    logic [31:0] r;
    lz = 32;
    for (int k = 0; k < 32; k++) begin
      if (m[k]) lz = 31 - k;
    end
    if (m == 32'h0) return 31'h0;
    mn = m << lz;
    e  = e_in - lz + 31 + 127;
    if (e >= 255) return {8'hFF, 23'h0};
    if (e < 1) begin
      sh = 1 - e;
      if (sh > 31) begin
        t    = 32'h0;
        lost = |mn;
      end else begin
        t    = mn >> sh;
        lost = |(mn & ((32'h1 << sh) - 32'h1));
      end
      field = 0;
    end else begin
      t     = mn;
      lost  = 1'b0;
      field = e - 1;
    end
    man = t[31:8];
    g   = t[7];
    st  = (|t[6:0]) | lost;
    inc = g & (st | man[0]);
    r   = (32'(field) << 23) + {8'h0, man} + {31'h0, inc};
    return r[30:0];
  endfunction

  // float32 times bf16, rounded to float32.
  function automatic logic [31:0] fmul_f32_bf16(input logic [31:0] a, input logic [15:0] b);
    logic        s;
    logic [7:0]  ea;
    logic [7:0]  eb;
    logic        a_nan;
    logic        b_nan;
    logic        a_inf;
    logic        b_inf;
    logic        a_zero;
    logic        b_zero;
    logic [31:0] m;
    int          e;
    s      = a[31] ^ b[15];
    ea     = a[30:23];
    eb     = b[14:7];
    a_nan  = (ea == 8'hFF) && (a[22:0] != 23'h0);
    b_nan  = (eb == 8'hFF) && (b[6:0] != 7'h0);
    a_inf  = (ea == 8'hFF) && (a[22:0] == 23'h0);
    b_inf  = (eb == 8'hFF) && (b[6:0] == 7'h0);
    a_zero = (a[30:0] == 31'h0);
    b_zero = (b[14:0] == 15'h0);
    if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) return QNAN_F32;
    if (a_inf || b_inf) return {s, 8'hFF, 23'h0};
    m = {8'h0, (ea != 8'h0), a[22:0]} * {24'h0, (eb != 8'h0), b[6:0]};
    e = ((ea == 8'h0) ? 1 : int'(ea)) + ((eb == 8'h0) ? 1 : int'(eb)) - 284;
    return {s, pack_mag(m, e)};
  endfunction

  // float32 add, rounded to nearest-even.
  function automatic logic [31:0] fadd_f32(input logic [31:0] a, input logic [31:0] b);
    logic        a_nan;
    logic        b_nan;
    logic        a_inf;
    logic        b_inf;
    logic [31:0] bg;
    logic [31:0] sm;
    int          ebg;
    int          esm;
    int          d;
    logic [26:0] xl;
    logic [26:0] xs;
    logic [26:0] xsh;
    logic        stk;
    logic [27:0] m;
    logic        s;
    a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'h0);
    b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'h0);
    a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'h0);
    b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'h0);
    if (a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31]))) return QNAN_F32;
    if (a_inf) return a;
    if (b_inf) return b;
    if (a[30:0] >= b[30:0]) begin
      bg = a;
      sm = b;
    end else begin
      bg = b;
      sm = a;
    end
    ebg = (bg[30:23] == 8'h0) ? 1 : int'(bg[30:23]);
    esm = (sm[30:23] == 8'h0) ? 1 : int'(sm[30:23]);
    d   = ebg - esm;
    xl  = {(bg[30:23] != 8'h0), bg[22:0], 3'b000};
    xs  = {(sm[30:23] != 8'h0), sm[22:0], 3'b000};
    if (d > 26) begin
      xsh = 27'h0;
      stk = |xs;
    end else begin
      xsh = xs >> d;
      stk = |(xs & ((27'h1 << d) - 27'h1));
    end
    xsh[0] = xsh[0] | stk;
    if (a[31] ^ b[31]) m = {1'b0, xl} - {1'b0, xsh};
    else               m = {1'b0, xl} + {1'b0, xsh};
    s = (m == 28'h0) ? (a[31] & b[31]) : bg[31];
    return {s, pack_mag({4'h0, m}, ebg - 153)};
  endfunction

  // float32 to bf16, nearest-even, any NaN to the canonical quiet NaN.
  function automatic logic [15:0] f32_to_bf16(input logic [31:0] f);
    logic [31:0] t;
    if ((f[30:23] == 8'hFF) && (f[22:0] != 23'h0)) return QNAN_BF16;
    t = f + 32'h0000_7FFF + {31'h0, f[16]};
    return t[31:16];
  endfunction

endpackage
`default_nettype wire

>>> sv/smx_queue.sv
// Small word queue between the front and back parts of the stream mixer.
`timescale 1ns / 1ps
`default_nettype none
module smx_queue #(
  parameter int DEPTH = 2
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push_i,
  input  smx_pkg::smx_entry_t wdata_i,
  output logic                full_o,
  input  wire                 pop_i,
  output logic                valid_o,
  output smx_pkg::smx_entry_t head_o
);
  import smx_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  smx_entry_t      mem_q [DEPTH];
  logic [AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            do_push;
  logic            do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    if (do_pop)  rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    if (do_push && !do_pop)      cnt_d = cnt_q + CW'(1);
    else if (do_pop && !do_push) cnt_d = cnt_q - CW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= wdata_i;
  end

endmodule
`default_nettype wire

>>> sv/smx_front.sv
// Front part: accepts input words, classifies them and queues them for the back part.
`timescale 1ns / 1ps
`default_nettype none
module smx_front #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  wire                 kind_i,
  input  wire [4:0]           coef_index_i,
  input  wire [31:0]          coef_value_i,
  input  wire [15:0]          layer_value_i,
  input  wire [smx_pkg::NS-1:0][15:0] res_i,
  input  wire                 pop_i,
  output logic                head_valid_o,
  output smx_pkg::smx_entry_t head_o
);
  import smx_pkg::*;

  smx_entry_t entry;
  logic       keep;
  logic       full;

  // Loads beyond the gain registers are dropped here and never queued.
  always_comb begin
    entry.value = coef_value_i;
    entry.layer = layer_value_i;
    entry.res   = res_i;
    entry.idx   = coef_index_i[IDX_W-1:0];
    keep        = 1'b1;
    if (kind_i) begin
      entry.op = OP_DATA;
    end else if (coef_index_i < 5'(MIX_N)) begin
      entry.op = OP_MIX;
    end else if (coef_index_i < 5'(MIX_N + NS)) begin
      entry.op  = OP_GAIN;
      entry.idx = IDX_W'(coef_index_i - 5'(MIX_N));
    end else begin
      entry.op = OP_MIX;
      keep     = 1'b0;
    end
  end

  assign in_stall_o = full;

  smx_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_valid_i && keep),
    .wdata_i (entry),
    .full_o  (full),
    .pop_i   (pop_i),
    .valid_o (head_valid_o),
    .head_o  (head_o)
  );

endmodule
`default_nettype wire

>>> sv/smx_back.sv
// Back part: coefficient store, product stage, add chain and bf16 output register.
`timescale 1ns / 1ps
`default_nettype none
module smx_back (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 head_valid_i,
  input  smx_pkg::smx_entry_t head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output logic [smx_pkg::NS-1:0][15:0] mixed_o
);
  import smx_pkg::*;

  logic [31:0] mix_q  [MIX_N];
  logic [31:0] gain_q [NS];

  logic [31:0] prd_d [NS][NS+1];
  logic [31:0] prd_q [NS][NS][NS+1];
  logic [31:0] acc_q [1:NS][NS];
  logic [NS:0] v_q;
  logic        out_valid_q;
  logic [NS-1:0][15:0] out_q;
  logic        en;
  logic        is_data;

  // Whole pipeline moves unless the output word is held.
  assign en      = !out_valid_q || !out_stall_i;
  assign is_data = (head_i.op == OP_DATA);
  assign pop_o   = head_valid_i && (!is_data || en);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MIX_N; k++) mix_q[k] <= 32'h0;
      for (int k = 0; k < NS; k++)    gain_q[k] <= 32'h0;
    end else if (pop_o) begin
      unique case (head_i.op)
        OP_MIX:  mix_q[head_i.idx] <= head_i.value;
        OP_GAIN: gain_q[head_i.idx[GAIN_W-1:0]] <= head_i.value;
        OP_DATA: ;
        default: ;
      endcase
    end
  end

  for (genvar o = 0; o < NS; o++) begin : g_lane
    assign prd_d[o][0] = fmul_f32_bf16(gain_q[o], head_i.layer);
    for (genvar i = 0; i < NS; i++) begin : g_term
      assign prd_d[o][i+1] = fmul_f32_bf16(mix_q[i*NS+o], head_i.res[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prd_q[0] <= prd_d;
      for (int k = 1; k < NS; k++) prd_q[k] <= prd_q[k-1];
      for (int o = 0; o < NS; o++) begin
        acc_q[1][o] <= fadd_f32(prd_q[0][o][0], prd_q[0][o][1]);
        for (int k = 2; k <= NS; k++) begin
          acc_q[k][o] <= fadd_f32(acc_q[k-1][o], prd_q[k-1][o][k]);
        end
        out_q[o]    <= f32_to_bf16(acc_q[NS][o]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v_q         <= {v_q[NS-1:0], pop_o && is_data};
      out_valid_q <= v_q[NS];
    end
  end

  assign out_valid_o = out_valid_q;
  assign mixed_o     = out_q;

  a_hold_stages: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(v_q))
    else $error("pipeline valids moved while output held");
  a_data_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && is_data) |=> v_q[0])
    else $error("popped data word did not enter product stage");
  a_last_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[NS] && en) |=> out_valid_q)
    else $error("last add stage word lost before output");
  a_gain_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && head_i.op == OP_GAIN) |=>
      (gain_q[$past(head_i.idx[GAIN_W-1:0])] == $past(head_i.value)))
    else $error("gain load not written");

endmodule
`default_nettype wire

>>> sv/stream_mix_bf16_4x4.sv
// Top level of the four-stream bf16 residual mixer.
//
// Input channel (in_valid_i / in_stall_o): each word is either a coefficient
// load (kind_i = 0) or a data word (kind_i = 1). Loads write one float32 word:
// index 0..15 is mix entry in*4+out, 16..19 the layer gain of an output,
// higher indexes are dropped. Loads give no output word.
// Output channel (out_valid_o / out_stall_i): one word of four bf16 results
// per data word, in input order.
// Pipeline: a data word accepted into the queue passes the queue slot, the
// product stage (20 float32 x bf16 multipliers), four float32 add stages
// and bf16 rounding into the output register, shown with out_valid_o.
// Throughput: one word per cycle if not stalled; add chain fully pipelined.
// A queue of QUEUE_DEPTH words decouples the front from the back; loads drain
// from the queue even while the output is held, data words wait in order.
// When out_stall_i holds a valid output, the back pipeline freezes and the
// queue fills; in_stall_o rises once the queue is full.
// Reset clears all coefficients to zero and empties the queue and pipeline.
`timescale 1ns / 1ps
`default_nettype none
module stream_mix_bf16_4x4 #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire         kind_i,
  input  wire  [4:0]  coef_index_i,
  input  wire  [31:0] coef_value_i,
  input  wire  [15:0] layer_value_i,
  input  wire  [15:0] res_0_i,
  input  wire  [15:0] res_1_i,
  input  wire  [15:0] res_2_i,
  input  wire  [15:0] res_3_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [15:0] mixed_0_o,
  output logic [15:0] mixed_1_o,
  output logic [15:0] mixed_2_o,
  output logic [15:0] mixed_3_o
);
  import smx_pkg::*;

  logic [NS-1:0][15:0] res;
  logic [NS-1:0][15:0] mixed;
  logic                head_valid;
  smx_entry_t          head;
  logic                pop;

  assign res = {res_3_i, res_2_i, res_1_i, res_0_i};

  smx_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .coef_index_i  (coef_index_i),
    .coef_value_i  (coef_value_i),
    .layer_value_i (layer_value_i),
    .res_i         (res),
    .pop_i         (pop),
    .head_valid_o  (head_valid),
    .head_o        (head)
  );

  smx_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .mixed_o      (mixed)
  );

  assign mixed_0_o = mixed[0];
  assign mixed_1_o = mixed[1];
  assign mixed_2_o = mixed[2];
  assign mixed_3_o = mixed[3];

endmodule
`default_nettype wire
